FILE: src/eight_bit_alu_register_execute_assert.svh
// assertion macros used by the checker file
`ifndef EIGHT_BIT_ALU_REGISTER_EXECUTE_ASSERT_SVH
`define EIGHT_BIT_ALU_REGISTER_EXECUTE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ALU8_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ALU8_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/alu8_pkg.sv
package alu8_pkg;

    typedef logic [5:0] cmd_t;
    typedef logic [7:0] byte_t;
    typedef logic [15:0] addr_t;

    // operation codes
    localparam cmd_t CMD_ADC = 6'd0;
    localparam cmd_t CMD_SBC = 6'd1;
    localparam cmd_t CMD_INC = 6'd2;
    localparam cmd_t CMD_DEC = 6'd3;
    localparam cmd_t CMD_AND = 6'd4;
    localparam cmd_t CMD_ORA = 6'd5;
    localparam cmd_t CMD_EOR = 6'd6;
    localparam cmd_t CMD_BIT = 6'd7;
    localparam cmd_t CMD_ASL = 6'd8;
    localparam cmd_t CMD_LSR = 6'd9;
    localparam cmd_t CMD_ROL = 6'd10;
    localparam cmd_t CMD_ROR = 6'd11;
    localparam cmd_t CMD_LDA = 6'd12;
    localparam cmd_t CMD_LDX = 6'd13;
    localparam cmd_t CMD_LDY = 6'd14;
    localparam cmd_t CMD_STA = 6'd15;
    localparam cmd_t CMD_STX = 6'd16;
    localparam cmd_t CMD_STY = 6'd17;
    localparam cmd_t CMD_CMP = 6'd18;
    localparam cmd_t CMD_CPX = 6'd19;
    localparam cmd_t CMD_CPY = 6'd20;
    localparam cmd_t CMD_TAX = 6'd21;
    localparam cmd_t CMD_TXA = 6'd22;
    localparam cmd_t CMD_TAY = 6'd23;
    localparam cmd_t CMD_TYA = 6'd24;
    localparam cmd_t CMD_TXS = 6'd25;
    localparam cmd_t CMD_TSX = 6'd26;
    localparam cmd_t CMD_INX = 6'd27;
    localparam cmd_t CMD_DEX = 6'd28;
    localparam cmd_t CMD_INY = 6'd29;
    localparam cmd_t CMD_DEY = 6'd30;
    localparam cmd_t CMD_SEC = 6'd31;
    localparam cmd_t CMD_CLC = 6'd32;
    localparam cmd_t CMD_SEI = 6'd33;
    localparam cmd_t CMD_CLI = 6'd34;
    localparam cmd_t CMD_SED = 6'd35;
    localparam cmd_t CMD_CLD = 6'd36;
    localparam cmd_t CMD_CLV = 6'd37;

    // status byte bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    // register values after reset
    localparam byte_t ACC_RESET   = 8'h00;
    localparam byte_t INDEX_RESET = 8'h00;
    localparam byte_t SP_RESET    = 8'hFD;
    localparam byte_t FLAGS_RESET = 8'h24;

    // zero and negative flags from a result byte
    function automatic byte_t with_zn(input byte_t p, input byte_t v);
        byte_t r;
        r = p;
        r[FLAG_Z] = (v == 8'h00);
        r[FLAG_N] = v[7];
        return r;
    endfunction

endpackage

FILE: src/eight_bit_alu_register_execute.sv
// execute stage of an 8-bit core with binary arithmetic only
//
// input channel (s_valid/s_ready): one request per instruction carrying the
// operation code, the operand byte and the effective address for stores.
// result channel (m_valid/m_ready): one result per request with the modified
// operand, A, X, Y, S and the status byte after the operation, plus a store
// request (address and data) for STA, STX and STY.
//
// a request passes an input register and then the result register, where
// its result is shown. one request per cycle is sustained while the receiver
// takes results; the flag and adder logic between the two registers is
// combinational, and each request sees the registers left by the one before
// it.
// when the receiver stalls, the result holds and one further request waits
// in the input register; s_ready drops only when both stages are full.
// reset (aresetn low at a clock edge) empties both stages and sets A, X, Y
// to zero, S to 0xFD and the status byte to 0x24.
module eight_bit_alu_register_execute (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_cmd,
    input  logic [7:0]  s_operand,
    input  logic [15:0] s_target_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_operand_out,
    output logic [7:0]  m_acc_out,
    output logic [7:0]  m_x_out,
    output logic [7:0]  m_y_out,
    output logic [7:0]  m_sp_out,
    output logic [7:0]  m_flags_out,
    output logic        m_store_valid,
    output logic [15:0] m_store_address,
    output logic [7:0]  m_store_data
);

    // input stage
    logic              in_valid_reg;
    alu8_pkg::cmd_t    cmd_reg;
    alu8_pkg::byte_t   operand_reg;
    alu8_pkg::addr_t   addr_reg;

    // architectural registers
    alu8_pkg::byte_t   acc_reg, acc_next;
    alu8_pkg::byte_t   x_reg, x_next;
    alu8_pkg::byte_t   y_reg, y_next;
    alu8_pkg::byte_t   sp_reg, sp_next;
    alu8_pkg::byte_t   flags_reg, flags_next;

    // result stage
    logic              out_valid_reg;
    alu8_pkg::byte_t   res_operand_reg, operand_next;
    logic              res_store_valid_reg, store_valid_next;
    alu8_pkg::addr_t   res_store_addr_reg, store_addr_next;
    alu8_pkg::byte_t   res_store_data_reg, store_data_next;

    logic              out_ready;
    logic              advance;

    // arithmetic helpers
    alu8_pkg::byte_t   add_operand;
    logic [8:0]        sum;
    alu8_pkg::byte_t   cmp_reg;
    logic [8:0]        diff;

    // handshake between the stages
    assign out_ready = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    // adder shared by ADC and SBC, subtractor shared by the compares
    always_comb begin
        add_operand = (cmd_reg == alu8_pkg::CMD_SBC) ? ~operand_reg : operand_reg;
        sum = {1'b0, acc_reg} + {1'b0, add_operand} + {8'h00, flags_reg[alu8_pkg::FLAG_C]};
        case (cmd_reg)
            alu8_pkg::CMD_CPX: cmp_reg = x_reg;
            alu8_pkg::CMD_CPY: cmp_reg = y_reg;
            default:           cmp_reg = acc_reg;
        endcase
        diff = {1'b0, cmp_reg} - {1'b0, operand_reg};
    end

    // operation decode and next register values
    always_comb begin
        acc_next         = acc_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        sp_next          = sp_reg;
        flags_next       = flags_reg;
        operand_next     = operand_reg;
        store_valid_next = 1'b0;
        store_addr_next  = 16'h0000;
        store_data_next  = 8'h00;
        case (cmd_reg)
            alu8_pkg::CMD_ADC, alu8_pkg::CMD_SBC: begin
                acc_next = sum[7:0];
                flags_next[alu8_pkg::FLAG_C] = sum[8];
                flags_next[alu8_pkg::FLAG_V] = (sum[7] ^ acc_reg[7]) & (sum[7] ^ add_operand[7]);
                flags_next = alu8_pkg::with_zn(flags_next, sum[7:0]);
            end
            alu8_pkg::CMD_INC: begin
                operand_next = operand_reg + 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
            end
            alu8_pkg::CMD_DEC: begin
                operand_next = operand_reg - 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
            end
            alu8_pkg::CMD_AND: begin
                acc_next = acc_reg & operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, acc_next);
            end
            alu8_pkg::CMD_ORA: begin
                acc_next = acc_reg | operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, acc_next);
            end
            alu8_pkg::CMD_EOR: begin
                acc_next = acc_reg ^ operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, acc_next);
            end
            alu8_pkg::CMD_BIT: begin
                flags_next[alu8_pkg::FLAG_Z] = ((acc_reg & operand_reg) == 8'h00);
                flags_next[alu8_pkg::FLAG_V] = operand_reg[6];
                flags_next[alu8_pkg::FLAG_N] = operand_reg[7];
            end
            alu8_pkg::CMD_ASL: begin
                operand_next = {operand_reg[6:0], 1'b0};
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
                flags_next[alu8_pkg::FLAG_C] = operand_reg[7];
            end
            alu8_pkg::CMD_LSR: begin
                operand_next = {1'b0, operand_reg[7:1]};
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
                flags_next[alu8_pkg::FLAG_C] = operand_reg[0];
            end
            alu8_pkg::CMD_ROL: begin
                operand_next = {operand_reg[6:0], flags_reg[alu8_pkg::FLAG_C]};
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
                flags_next[alu8_pkg::FLAG_C] = operand_reg[7];
            end
            alu8_pkg::CMD_ROR: begin
                operand_next = {flags_reg[alu8_pkg::FLAG_C], operand_reg[7:1]};
                flags_next = alu8_pkg::with_zn(flags_reg, operand_next);
                flags_next[alu8_pkg::FLAG_C] = operand_reg[0];
            end
            alu8_pkg::CMD_LDA: begin
                acc_next = operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, operand_reg);
            end
            alu8_pkg::CMD_LDX: begin
                x_next = operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, operand_reg);
            end
            alu8_pkg::CMD_LDY: begin
                y_next = operand_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, operand_reg);
            end
            alu8_pkg::CMD_STA: begin
                store_valid_next = 1'b1;
                store_addr_next  = addr_reg;
                store_data_next  = acc_reg;
            end
            alu8_pkg::CMD_STX: begin
                store_valid_next = 1'b1;
                store_addr_next  = addr_reg;
                store_data_next  = x_reg;
            end
            alu8_pkg::CMD_STY: begin
                store_valid_next = 1'b1;
                store_addr_next  = addr_reg;
                store_data_next  = y_reg;
            end
            alu8_pkg::CMD_CMP, alu8_pkg::CMD_CPX, alu8_pkg::CMD_CPY: begin
                flags_next[alu8_pkg::FLAG_C] = !diff[8];
                flags_next[alu8_pkg::FLAG_Z] = (cmp_reg == operand_reg);
                flags_next[alu8_pkg::FLAG_N] = diff[7];
            end
            alu8_pkg::CMD_TAX: begin
                x_next = acc_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, acc_reg);
            end
            alu8_pkg::CMD_TXA: begin
                acc_next = x_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, x_reg);
            end
            alu8_pkg::CMD_TAY: begin
                y_next = acc_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, acc_reg);
            end
            alu8_pkg::CMD_TYA: begin
                acc_next = y_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, y_reg);
            end
            alu8_pkg::CMD_TXS: begin
                sp_next = x_reg;
            end
            alu8_pkg::CMD_TSX: begin
                x_next = sp_reg;
                flags_next = alu8_pkg::with_zn(flags_reg, sp_reg);
            end
            alu8_pkg::CMD_INX: begin
                x_next = x_reg + 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, x_next);
            end
            alu8_pkg::CMD_DEX: begin
                x_next = x_reg - 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, x_next);
            end
            alu8_pkg::CMD_INY: begin
                y_next = y_reg + 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, y_next);
            end
            alu8_pkg::CMD_DEY: begin
                y_next = y_reg - 8'd1;
                flags_next = alu8_pkg::with_zn(flags_reg, y_next);
            end
            alu8_pkg::CMD_SEC: flags_next[alu8_pkg::FLAG_C] = 1'b1;
            alu8_pkg::CMD_CLC: flags_next[alu8_pkg::FLAG_C] = 1'b0;
            alu8_pkg::CMD_SEI: flags_next[alu8_pkg::FLAG_I] = 1'b1;
            alu8_pkg::CMD_CLI: flags_next[alu8_pkg::FLAG_I] = 1'b0;
            alu8_pkg::CMD_SED: flags_next[alu8_pkg::FLAG_D] = 1'b1;
            alu8_pkg::CMD_CLD: flags_next[alu8_pkg::FLAG_D] = 1'b0;
            alu8_pkg::CMD_CLV: flags_next[alu8_pkg::FLAG_V] = 1'b0;
            // unused codes leave everything as it is
            default: begin
            end
        endcase
    end

    // control state and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= alu8_pkg::ACC_RESET;
            x_reg         <= alu8_pkg::INDEX_RESET;
            y_reg         <= alu8_pkg::INDEX_RESET;
            sp_reg        <= alu8_pkg::SP_RESET;
            flags_reg     <= alu8_pkg::FLAGS_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                acc_reg   <= acc_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                sp_reg    <= sp_next;
                flags_reg <= flags_next;
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            operand_reg <= s_operand;
            addr_reg    <= s_target_address;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_operand_reg     <= operand_next;
            res_store_valid_reg <= store_valid_next;
            res_store_addr_reg  <= store_addr_next;
            res_store_data_reg  <= store_data_next;
        end
    end

    // the register copies in the result equal the architectural registers
    assign m_valid         = out_valid_reg;
    assign m_operand_out   = res_operand_reg;
    assign m_acc_out       = acc_reg;
    assign m_x_out         = x_reg;
    assign m_y_out         = y_reg;
    assign m_sp_out        = sp_reg;
    assign m_flags_out     = flags_reg;
    assign m_store_valid   = res_store_valid_reg;
    assign m_store_address = res_store_addr_reg;
    assign m_store_data    = res_store_data_reg;

endmodule

FILE: src/alu8_checker.sv
`include "eight_bit_alu_register_execute_assert.svh"

module alu8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_operand_out,
    input logic [7:0]  m_acc_out,
    input logic [7:0]  m_x_out,
    input logic [7:0]  m_y_out,
    input logic [7:0]  m_sp_out,
    input logic [7:0]  m_flags_out,
    input logic        m_store_valid,
    input logic [15:0] m_store_address,
    input logic [7:0]  m_store_data
);

    // every result field together, and the stall condition
    logic [72:0] result_bits;
    logic        stalled;

    assign result_bits = {m_operand_out, m_acc_out, m_x_out, m_y_out, m_sp_out, m_flags_out,
                          m_store_valid, m_store_address, m_store_data};
    assign stalled     = m_valid && !m_ready;

    // a stalled result keeps its contents
    `ALU8_ASSERT_NEXT(a_result_hold, aclk, aresetn, stalled,
                      m_valid && $stable(result_bits), "stalled result changed")

    // no store request means zero address and data
    `ALU8_ASSERT_NOW(a_no_store_zero, aclk, aresetn, m_valid && !m_store_valid,
                     (m_store_address == 16'h0000) && (m_store_data == 8'h00),
                     "idle store fields not zero")

    // stores change no register, so the data matches A, X or Y
    `ALU8_ASSERT_NOW(a_store_data_src, aclk, aresetn, m_valid && m_store_valid,
                     (m_store_data == m_acc_out) || (m_store_data == m_x_out) ||
                     (m_store_data == m_y_out), "store data is not a register value")

    // the two unused status bits keep their reset value
    `ALU8_ASSERT_NOW(a_fixed_flag_bits, aclk, aresetn, m_valid,
                     m_flags_out[5:4] == alu8_pkg::FLAGS_RESET[5:4], "fixed status bits changed")

    // a ready receiver never holds back a request
    `ALU8_ASSERT_NOW(a_ready_passes, aclk, aresetn, m_ready, s_ready,
                     "request blocked while the receiver is ready")

endmodule

bind eight_bit_alu_register_execute alu8_checker u_alu8_checker (.*);
